[hw/rtl/ehct_pkg.sv]
`default_nettype none
package ehct_pkg;
   localparam int NumBucketsDef = 1117;
   localparam int NumNodesDef   = 1024;
   localparam int KeyBytesDef   = 8;
   localparam int ValueBytesDef = 8;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, start hash
      logic hash_step;  // one key byte into hash
      logic mod_start;  // start bucket remainder
      logic head_rd;    // read bucket head
      logic node_rd;    // read node at pointer
      logic follow;     // pointer takes node next
      logic take_head;  // pointer takes head
      logic wr_node;    // write new node
      logic wr_head;    // bucket head gets new node
      logic wr_link;    // pointer node next gets new node
      logic set_rsp;    // load response register
      logic [1:0] rsp_status;
      logic rsp_value;  // response carries node value
   } ehct_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_find;
      logic hash_done;
      logic mod_done;
      logic head_valid;
      logic next_valid;
      logic match;
      logic full;
      logic steps_over;
   } ehct_stat_type;
endpackage
`default_nettype wire

[hw/rtl/ehct_ctrl.sv]
`default_nettype none
module ehct_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_fire,
   output logic                        busy,
   input  wire logic                   rsp_free,
   input  wire ehct_pkg::ehct_stat_type st,
   output ehct_pkg::ehct_cmd_type      cmd
);
   import ehct_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_HASH, S_MOD, S_HEAD, S_HEADW, S_NODE, S_NODEW, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic       found_ff, found_in;
   logic       full_ff, full_in;
   logic [1:0] status_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         full_ff  <= full_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      if (!st.is_find) status_sel = full_ff ? ST_FULL : ST_OK;
      else status_sel = found_ff ? ST_OK : ST_NOT_FOUND;
   end

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      full_in  = full_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               found_in = 1'b0;
               full_in  = 1'b0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (st.hash_done) begin
               cmd.mod_start = 1'b1;
               state_in = S_MOD;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_MOD: begin
            if (st.mod_done) begin
               if (!st.is_find && st.full) begin
                  full_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.head_rd = 1'b1;
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: state_in = S_HEADW;
         S_HEADW: begin
            if (st.is_find) begin
               if (st.head_valid) begin
                  cmd.take_head = 1'b1;
                  cmd.node_rd = 1'b1;
                  state_in = S_NODE;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cmd.wr_node = 1'b1;
               if (st.head_valid) begin
                  cmd.take_head = 1'b1;
                  cmd.node_rd = 1'b1;
                  state_in = S_NODE;
               end else begin
                  cmd.wr_head = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_NODE: state_in = S_NODEW;
         S_NODEW: begin
            if (st.is_find && st.match) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (st.is_find && (!st.next_valid || st.steps_over)) begin
               state_in = S_DONE;
            end else if (!st.is_find && (!st.next_valid || st.steps_over)) begin
               cmd.wr_link = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.follow = 1'b1;
               cmd.node_rd = 1'b1;
               state_in = S_NODE;
            end
         end
         S_DONE: begin
            cmd.rsp_status = status_sel;
            cmd.rsp_value  = st.is_find && found_ff;
            if (rsp_free) begin
               cmd.set_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[hw/rtl/ehct_dp.sv]
`default_nettype none
module ehct_dp #(
   parameter int NUM_BUCKETS = ehct_pkg::NumBucketsDef,
   parameter int NUM_NODES   = ehct_pkg::NumNodesDef,
   parameter int KEY_BYTES   = ehct_pkg::KeyBytesDef,
   parameter int VALUE_BYTES = ehct_pkg::ValueBytesDef
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_op,
   input  wire logic [8*KEY_BYTES-1:0]  req_key,
   input  wire logic [3:0]              req_key_len,
   input  wire logic [8*VALUE_BYTES-1:0] req_value,
   input  wire logic [3:0]              req_vsize,
   input  wire ehct_pkg::ehct_cmd_type  cmd,
   output ehct_pkg::ehct_stat_type      st,
   output logic                         clear_busy,
   output logic [1:0]                   rsp_status,
   output logic [8*VALUE_BYTES-1:0]     rsp_value_out,
   output logic [3:0]                   rsp_vsize_out
);
   import ehct_pkg::*;

   localparam int KW = 8*KEY_BYTES;
   localparam int VW = 8*VALUE_BYTES;
   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int NW = $clog2(NUM_NODES);
   localparam int CW = $clog2(NUM_NODES + 1);
   localparam int SW = $clog2(NUM_NODES + 2);
   localparam int LW = $clog2(KEY_BYTES + 1);
   localparam logic [31:0] MRecip = 32'((64'd1 << 32) / 64'(NUM_BUCKETS));

   // request capture
   logic          op_ff;
   logic [KW-1:0] key_ff;
   logic [LW-1:0] klen_ff;
   logic [VW-1:0] val_ff;
   logic [3:0]    vsize_ff;
   logic [3:0]    klen_sat, vsize_sat;
   logic [KW-1:0] kmask;
   logic [VW-1:0] vmask;

   always_comb begin
      klen_sat  = (req_key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req_key_len;
      vsize_sat = (req_vsize > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : req_vsize;
      for (int i = 0; i < KEY_BYTES; i++) kmask[8*i +: 8] = {8{4'(i) < klen_sat}};
      for (int i = 0; i < VALUE_BYTES; i++) vmask[8*i +: 8] = {8{4'(i) < vsize_sat}};
   end

   // hash
   logic [31:0]   h_ff, h_in;
   logic [LW-1:0] hi_ff;
   logic [7:0]    hbyte;
   logic [31:0]   ht;

   assign hbyte = key_ff[8*hi_ff[$clog2(KEY_BYTES > 1 ? KEY_BYTES : 2)-1:0] +: 8];
   always_comb begin
      ht = (h_ff << 4) + 32'(hbyte);
      if ((ht & 32'hf000_0000) != 32'd0) ht = (ht ^ ((ht & 32'hf000_0000) >> 24))
                                              & ~(ht & 32'hf000_0000);
      h_in = ht;
   end

   // bucket remainder by reciprocal multiply, one correction step
   logic [31:0]   mh_ff;
   logic [63:0]   mp_ff;
   logic [31:0]   mr0_ff;
   logic [BW-1:0] mr_ff;
   logic [1:0]    mc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         key_ff   <= req_key & kmask;
         klen_ff  <= LW'(klen_sat);
         val_ff   <= req_value & vmask;
         vsize_ff <= vsize_sat;
         h_ff     <= 32'd0;
         hi_ff    <= '0;
      end else if (cmd.hash_step) begin
         h_ff  <= h_in;
         hi_ff <= hi_ff + LW'(1);
      end
      if (cmd.mod_start) mh_ff <= h_ff & 32'h7fff_ffff;
      mp_ff  <= 64'(mh_ff) * 64'(MRecip);
      mr0_ff <= mh_ff - mp_ff[63:32] * 32'(NUM_BUCKETS);
      if (mr0_ff >= 32'(NUM_BUCKETS)) mr_ff <= BW'(mr0_ff - 32'(NUM_BUCKETS));
      else mr_ff <= BW'(mr0_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) mc_ff <= 2'd0;
      else if (cmd.mod_start) mc_ff <= 2'd3;
      else if (mc_ff != 2'd0) mc_ff <= mc_ff - 2'd1;
   end

   // bucket heads with clearing pass
   logic [NW-1:0] head_mem [NUM_BUCKETS];
   logic          headv_mem [NUM_BUCKETS];
   logic [NW-1:0] head_q;
   logic          headv_q;
   logic [BW-1:0] clr_ff;
   logic          clr_on_ff;
   logic [BW-1:0] bkt;
   assign bkt = mr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         clr_on_ff <= 1'b1;
      end else if (clr_on_ff) begin
         if (clr_ff == BW'(NUM_BUCKETS - 1)) clr_on_ff <= 1'b0;
         clr_ff <= clr_ff + BW'(1);
      end
   end
   assign clear_busy = clr_on_ff;

   logic [CW-1:0] used_ff;
   always_ff @(posedge clock) begin
      if (clr_on_ff) begin
         headv_mem[clr_ff] <= 1'b0;
      end else if (cmd.wr_head) begin
         headv_mem[bkt] <= 1'b1;
         head_mem[bkt]  <= used_ff[NW-1:0];
      end
      if (cmd.head_rd) begin
         head_q  <= head_mem[bkt];
         headv_q <= headv_mem[bkt];
      end
   end

   // node pool
   localparam int NDW = KW + 4 + VW + 4 + NW + 1;
   logic [NDW-1:0] node_mem [NUM_NODES];
   logic [NDW-1:0] node_q;
   logic [NW-1:0]  ptr_ff;
   logic [SW-1:0]  steps_ff;
   logic [NW-1:0]  rd_addr;

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (cmd.wr_node) used_ff <= used_ff + CW'(1);
   end

   always_comb begin
      rd_addr = ptr_ff;
      if (cmd.take_head) rd_addr = head_q;
      else if (cmd.follow) rd_addr = node_q[NW:1];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_head) begin
         ptr_ff   <= head_q;
         steps_ff <= '0;
      end else if (cmd.follow) begin
         ptr_ff   <= node_q[NW:1];
         steps_ff <= steps_ff + SW'(1);
      end
   end

   // index of the new node for the tail link
   logic [NW-1:0] new_idx_ff;
   always_ff @(posedge clock) begin
      if (cmd.wr_node) new_idx_ff <= used_ff[NW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_node) begin
         node_mem[used_ff[NW-1:0]] <= {key_ff, 4'(klen_ff), val_ff, vsize_ff, NW'(0), 1'b0};
      end else if (cmd.wr_link) begin
         node_mem[ptr_ff] <= {node_q[NDW-1:NW+1], new_idx_ff, 1'b1};
      end
      if (cmd.node_rd) node_q <= node_mem[rd_addr];
   end

   logic [KW-1:0] n_key;
   logic [3:0]    n_klen;
   logic [VW-1:0] n_val;
   logic [3:0]    n_vsize;
   assign {n_key, n_klen, n_val, n_vsize} = node_q[NDW-1:NW+1];

   assign st.is_find    = op_ff;
   assign st.hash_done  = (hi_ff == klen_ff);
   assign st.mod_done   = (mc_ff == 2'd0);
   assign st.head_valid = headv_q;
   assign st.next_valid = node_q[0];
   assign st.match      = (n_klen == 4'(klen_ff)) && (n_key == key_ff);
   assign st.full       = (used_ff >= CW'(NUM_NODES));
   assign st.steps_over = (steps_ff >= SW'(NUM_NODES));

   // response value held
   logic [VW-1:0] fval_ff;
   logic [3:0]    fsize_ff;
   always_ff @(posedge clock) begin
      if (op_ff && st.match && !cmd.node_rd && !cmd.set_rsp) begin
         fval_ff  <= n_val;
         fsize_ff <= n_vsize;
      end
      if (cmd.set_rsp) begin
         rsp_status    <= cmd.rsp_status;
         rsp_value_out <= cmd.rsp_value ? fval_ff : '0;
         rsp_vsize_out <= cmd.rsp_value ? fsize_ff : 4'd0;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/elf_hash_chained_table.sv]
// channel  | ports                          | payload
// request  | req_tvalid/req_tready/req_tdata| op, key, key_len, value, value size
// response | rsp_tvalid/rsp_tready/rsp_tdata| status, value_out, value size out
// a request runs from accept to accept through these steps:
// hash steps, bucket remainder, head read, then node reads; insert walks the whole chain
// an insert into a full pool ends after the bucket remainder, with no table read
// after reset the bucket heads are cleared first, with req_tready low
// one request in flight; a finished request waits while the response is not taken
`default_nettype none
module elf_hash_chained_table #(
   parameter int NUM_BUCKETS = ehct_pkg::NumBucketsDef,
   parameter int NUM_NODES   = ehct_pkg::NumNodesDef,
   parameter int KEY_BYTES   = ehct_pkg::KeyBytesDef,
   parameter int VALUE_BYTES = ehct_pkg::ValueBytesDef
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // op, key, key_len, value, value size
   input  wire logic [8*((1+16*KEY_BYTES/2+4+8*VALUE_BYTES+4+7)/8)-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // status, value_out, value size out
   output logic [8*((2+8*VALUE_BYTES+4+7)/8)-1:0] rsp_tdata
);
   import ehct_pkg::*;
   localparam int KW = 8*KEY_BYTES;
   localparam int VW = 8*VALUE_BYTES;
   localparam int RspW = 8*((2+VW+4+7)/8);

   ehct_cmd_type  cmd;
   ehct_stat_type st;
   logic busy, clear_busy, rsp_v_ff, req_fire;
   logic [1:0]    r_status;
   logic [VW-1:0] r_val;
   logic [3:0]    r_size;

   assign req_tready = !busy && !clear_busy;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (cmd.set_rsp) rsp_v_ff <= 1'b1;
      else if (rsp_tready) rsp_v_ff <= 1'b0;
   end
   assign rsp_tvalid = rsp_v_ff;

   ehct_ctrl u_ctrl (
      .clock, .reset, .req_fire, .busy,
      .rsp_free(!rsp_v_ff || rsp_tready), .st, .cmd
   );

   ehct_dp #(
      .NUM_BUCKETS(NUM_BUCKETS), .NUM_NODES(NUM_NODES),
      .KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)
   ) u_dp (
      .clock, .reset,
      .req_op(req_tdata[0]),
      .req_key(req_tdata[KW:1]),
      .req_key_len(req_tdata[KW+4:KW+1]),
      .req_value(req_tdata[KW+VW+4:KW+5]),
      .req_vsize(req_tdata[KW+VW+8:KW+VW+5]),
      .cmd, .st, .clear_busy,
      .rsp_status(r_status), .rsp_value_out(r_val), .rsp_vsize_out(r_size)
   );

   assign rsp_tdata = RspW'({r_size, r_val, r_status});
endmodule
`default_nettype wire

[hw/rtl/ehct_check.sv]
`default_nettype none
module ehct_check (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [71:0] rsp_tdata
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped under stall");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[69:2] == 68'd0)
      else $error("failed response carries data");
endmodule

bind elf_hash_chained_table ehct_check u_ehct_check (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata(rsp_tdata[71:0])
);
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ehct_pkg::*;

   localparam int Nodes = NumNodesDef;
   localparam int ReqW = 144;
   localparam int RspW = 72;
   localparam int CycleLimit = 3000000;

   typedef struct packed {
      logic [3:0]  size;
      logic [63:0] value;
      logic [1:0]  status;
   } lookup_result_type;

   class table_scoreboard;
      logic [63:0]       stored_key[$];
      logic [3:0]        stored_len[$];
      logic [63:0]       stored_value[$];
      logic [3:0]        stored_size[$];
      lookup_result_type awaited[$];
      int                mismatches;

      static function logic [63:0] byte_mask(int n);
         if (n >= 8) return '1;
         return (64'd1 << (n * 8)) - 64'd1;
      endfunction

      function void note_request(logic op, logic [63:0] key, logic [3:0] key_len,
                                 logic [63:0] value, logic [3:0] val_len);
         int klen, vsize;
         logic [63:0] k;
         lookup_result_type r;
         klen = key_len > 8 ? 8 : key_len;
         vsize = val_len > 8 ? 8 : val_len;
         k = key & byte_mask(klen);
         r = '{status: ST_OK, value: '0, size: '0};
         if (op == OP_INSERT) begin
            if (stored_key.size() >= Nodes) begin
               r.status = ST_FULL;
            end else begin
               stored_key.push_back(k);
               stored_len.push_back(4'(klen));
               stored_value.push_back(value & byte_mask(vsize));
               stored_size.push_back(4'(vsize));
            end
         end else begin
            r.status = ST_NOT_FOUND;
            // chains are in insertion order, so the oldest equal key wins
            foreach (stored_key[i]) begin
               if (stored_len[i] == klen && stored_key[i] == k) begin
                  r = '{status: ST_OK, value: stored_value[i], size: stored_size[i]};
                  break;
               end
            end
         end
         awaited.push_back(r);
      endfunction

      function void check_response(lookup_result_type got);
         lookup_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status || got.value !== want.value
             || got.size !== want.size) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspW-1:0] rsp_tdata;

   table_scoreboard sb = new();
   bit steady = 1'b0;
   int cycles = 0;
   logic [63:0] pool_key[24];
   logic [3:0]  pool_len[24];

   elf_hash_chained_table u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata[69:0]);
      if (cycles > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_request(logic op, logic [63:0] key, logic [3:0] key_len,
                               logic [63:0] value, logic [3:0] val_len);
      while (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, val_len, value, key_len, key, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, key, key_len, value, val_len);
      @(negedge clock);
   endtask

   task automatic send_pooled(bit insert_only);
      int p;
      logic [63:0] k, junk, v;
      logic [3:0] len;
      logic op;
      v = {$urandom, $urandom};
      op = insert_only ? OP_INSERT : logic'($urandom_range(1));
      if ($urandom_range(99) < 80) begin
         p = $urandom_range(23);
         len = pool_len[p];
         junk = {$urandom, $urandom};
         k = pool_key[p] ^ (junk & ~table_scoreboard::byte_mask(len > 8 ? 8 : len));
      end else begin
         k = {$urandom, $urandom};
         len = 4'($urandom_range(15));
      end
      send_request(op, k, len, v, 4'($urandom_range(15)));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      foreach (pool_key[i]) begin
         pool_key[i] = {$urandom, $urandom};
         pool_len[i] = 4'($urandom_range(15));
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      send_request(OP_FIND, '1, 4'd8, '0, 4'd0);
      send_request(OP_INSERT, '1, 4'd8, '1, 4'd8);
      send_request(OP_FIND, '1, 4'd8, '0, 4'd0);
      send_request(OP_INSERT, 64'h0, 4'd0, 64'h1234, 4'd2);
      send_request(OP_FIND, 64'hdead_beef, 4'd0, '0, 4'd0);
      send_request(OP_INSERT, 64'h0, 4'd1, '1, 4'd0);
      send_request(OP_FIND, 64'hff00, 4'd1, '1, 4'd15);
      send_request(OP_INSERT, 64'h0123_4567_89ab_cdef, 4'd15, 64'h5555_aaaa_5555_aaaa, 4'd15);
      send_request(OP_FIND, 64'h0123_4567_89ab_cdef, 4'd8, '0, 4'd0);
      send_request(OP_INSERT, 64'hffff_ff00_00ab_cdef, 4'd3, 64'h1111_2222_3333_4444, 4'd3);
      send_request(OP_INSERT, 64'h0000_0000_00ab_cdef, 4'd3, 64'h9999, 4'd5);
      send_request(OP_FIND, 64'h1234_5600_00ab_cdef, 4'd3, '0, 4'd0);
      send_request(OP_FIND, 64'h00ab_cdef, 4'd4, '0, 4'd0);
      send_request(OP_FIND, 64'h0123_4567_89ab_cdef, 4'd7, '0, 4'd0);
      drain();

      // random mix, steady stretch in the middle
      for (int i = 0; i < 386; i++) begin
         steady = (i >= 150 && i < 230);
         send_pooled(1'b0);
         if (i == 300) drain();
      end
      steady = 1'b0;

      drain();
      repeat (2200) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
